### hdl/etq_pkg.sv
// ----------------------------------------------------------------------------
// etq_pkg
// Shared types and constants for the event timing qualifier.
// ----------------------------------------------------------------------------
package etq_pkg;

    // fixed widths of the port fields
    localparam int SLOT_BITS     = 16;
    localparam int FIELD_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int RADIUS_BITS   = 33;
    localparam int CFG_DATA_BITS = 33;

    // status codes, first failing cut wins
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_TRACK  = 3'd1;
    localparam logic [2:0] ST_PEAK   = 3'd2;
    localparam logic [2:0] ST_REFT   = 3'd3;
    localparam logic [2:0] ST_FID    = 3'd4;
    localparam logic [2:0] ST_ENERGY = 3'd5;
    localparam logic [2:0] ST_EMPTY  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_SQ  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_MIN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_MAX   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENERGY_THR = 3'd5;

    localparam logic [RADIUS_BITS-1:0] RADIUS_SQ_RST = 33'd589824;
    localparam logic [FIELD_BITS-1:0]  PEAK_MAX_RST  = 16'hFFFF;

    // load enables of the two stages inside a mean unit
    typedef struct packed {
        logic a;
        logic b;
    } t_mean_en;

    // cut results carried down the pipeline, set means the cut failed
    typedef struct packed {
        logic trk;
        logic peak;
        logic reft;
        logic energy;
    } t_cut;

endpackage

### hdl/event_timing_qualifier.sv
// ----------------------------------------------------------------------------
// event_timing_qualifier
// Qualifies detector events by a chain of cuts and computes their timing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  event   | in        | i_valid / o_stall          | track, peak, energy, times
//  result  | out       | o_valid / i_stall          | status, time diff, dev, count
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  five register stages: unpack and sums, squares and mean divide, radius cut
//  and mean sign, deviations and status, max and output register.
//  one event per clock unless i_stall has filled every stage; o_valid is the stage 5 valid flag.
//  reset (synchronous, active low) empties the pipeline and restores registers.
//  each stage moves when it is empty or the next one moves, so bubbles close up
//  under i_stall and the input stalls only when every stage is full.
// ----------------------------------------------------------------------------
module event_timing_qualifier
    import etq_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int POS_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // event channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_track_ok,
    input  logic [FIELD_BITS-1:0]    i_track_x,
    input  logic [FIELD_BITS-1:0]    i_track_y,
    input  logic [FIELD_BITS-1:0]    i_ref_peak,
    input  logic                     i_ref_time_valid,
    input  logic [FIELD_BITS-1:0]    i_energy_sum,
    input  logic [4*SLOT_BITS-1:0]   i_down_times,
    input  logic [4*SLOT_BITS-1:0]   i_up_times,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic [FIELD_BITS-1:0]    o_time_diff,
    output logic [FIELD_BITS-1:0]    o_worst_deviation,
    output logic [3:0]               o_channel_count,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int TB  = TIME_BITS;
    localparam int P   = POS_BITS;
    localparam int SQW = 2 * P + 1;
    localparam int R2W = 2 * P + 2;
    localparam int CW  = (R2W > RADIUS_BITS) ? R2W : RADIUS_BITS;
    localparam logic signed [TB-1:0] ABSENT = {1'b1, {(TB-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [FIELD_BITS-1:0]  r_center_x;
    logic [FIELD_BITS-1:0]  r_center_y;
    logic [RADIUS_BITS-1:0] r_radius_sq;
    logic [FIELD_BITS-1:0]  r_peak_min;
    logic [FIELD_BITS-1:0]  r_peak_max;
    logic [FIELD_BITS-1:0]  r_energy_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius_sq  <= RADIUS_SQ_RST;
            r_peak_min   <= '0;
            r_peak_max   <= PEAK_MAX_RST;
            r_energy_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:   r_center_x   <= i_cfg_data[FIELD_BITS-1:0];
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data[FIELD_BITS-1:0];
                CFG_RADIUS_SQ:  r_radius_sq  <= i_cfg_data[RADIUS_BITS-1:0];
                CFG_PEAK_MIN:   r_peak_min   <= i_cfg_data[FIELD_BITS-1:0];
                CFG_PEAK_MAX:   r_peak_max   <= i_cfg_data[FIELD_BITS-1:0];
                CFG_ENERGY_THR: r_energy_thr <= i_cfg_data[FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [5:1] r_v;
    logic [5:1] w_rdy;

    always_comb begin
        w_rdy[5] = !r_v[5] || !i_stall;
        for (int k = 4; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[1];
    assign o_valid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 5; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- stage 1: unpack, sums, cuts ----------------
    logic signed [TB-1:0] n1_t [8];
    logic [7:0]           n1_ok;
    logic signed [TB+1:0] n1_ds, n1_us, n1_s3;
    logic [2:0]           n1_nd, n1_nu, n1_n3;
    logic signed [P:0]    n1_dx, n1_dy;
    t_cut                 n1_cut;

    always_comb begin
        n1_ds = '0;
        n1_us = '0;
        n1_s3 = '0;
        n1_nd = '0;
        n1_nu = '0;
        n1_n3 = '0;
        for (int c = 0; c < 4; c++) begin
            n1_t[c]     = signed'(i_down_times[SLOT_BITS*c +: TB]);
            n1_t[c+4]   = signed'(i_up_times[SLOT_BITS*c +: TB]);
            n1_ok[c]    = n1_t[c] != ABSENT;
            n1_ok[c+4]  = n1_t[c+4] != ABSENT;
            if (n1_ok[c]) begin
                n1_ds = n1_ds + (TB+2)'(n1_t[c]);
                n1_nd = n1_nd + 3'd1;
            end
            if (n1_ok[c+4]) begin
                n1_us = n1_us + (TB+2)'(n1_t[c+4]);
                n1_nu = n1_nu + 3'd1;
            end
            // last up channel stays out of the deviation group
            if (n1_ok[c+4] && c < 3) begin
                n1_s3 = n1_s3 + (TB+2)'(n1_t[c+4]);
                n1_n3 = n1_n3 + 3'd1;
            end
        end
        n1_dx = (P+1)'(signed'(i_track_x[P-1:0])) - (P+1)'(signed'(r_center_x[P-1:0]));
        n1_dy = (P+1)'(signed'(i_track_y[P-1:0])) - (P+1)'(signed'(r_center_y[P-1:0]));
        n1_cut.trk    = !i_track_ok;
        n1_cut.peak   = (i_ref_peak < r_peak_min) || (i_ref_peak > r_peak_max);
        n1_cut.reft   = !i_ref_time_valid;
        n1_cut.energy = i_energy_sum < r_energy_thr;
    end

    logic signed [TB-1:0] r1_t [8];
    logic [7:0]           r1_ok;
    logic signed [TB+1:0] r1_ds, r1_us, r1_s3;
    logic [2:0]           r1_nd, r1_nu, r1_n3;
    logic signed [P:0]    r1_dx, r1_dy;
    t_cut                 r1_cut;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_t   <= n1_t;
            r1_ok  <= n1_ok;
            r1_ds  <= n1_ds;
            r1_us  <= n1_us;
            r1_s3  <= n1_s3;
            r1_nd  <= n1_nd;
            r1_nu  <= n1_nu;
            r1_n3  <= n1_n3;
            r1_dx  <= n1_dx;
            r1_dy  <= n1_dy;
            r1_cut <= n1_cut;
        end
    end

    // ---------------- stages 2-3: means ----------------
    t_mean_en             w_mean_en;
    logic signed [TB-1:0] w_dm, w_um, w_m3;

    assign w_mean_en.a = w_rdy[2];
    assign w_mean_en.b = w_rdy[3];

    etq_mean #(.TB(TB)) u_mean_down (
        .i_clk  (i_clk),
        .i_en   (w_mean_en),
        .i_sum  (r1_ds),
        .i_cnt  (r1_nd),
        .o_mean (w_dm)
    );

    etq_mean #(.TB(TB)) u_mean_up (
        .i_clk  (i_clk),
        .i_en   (w_mean_en),
        .i_sum  (r1_us),
        .i_cnt  (r1_nu),
        .o_mean (w_um)
    );

    etq_mean #(.TB(TB)) u_mean_up3 (
        .i_clk  (i_clk),
        .i_en   (w_mean_en),
        .i_sum  (r1_s3),
        .i_cnt  (r1_n3),
        .o_mean (w_m3)
    );

    // ---------------- stage 2: squares ----------------
    logic signed [R2W-1:0] n2_dx2, n2_dy2;
    logic [SQW-1:0]        r2_dx2, r2_dy2;
    logic signed [TB-1:0]  r2_t [8];
    logic [7:0]            r2_ok;
    logic [2:0]            r2_nd, r2_nu;
    t_cut                  r2_cut;

    assign n2_dx2 = r1_dx * r1_dx;
    assign n2_dy2 = r1_dy * r1_dy;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_dx2 <= n2_dx2[SQW-1:0];
            r2_dy2 <= n2_dy2[SQW-1:0];
            r2_t   <= r1_t;
            r2_ok  <= r1_ok;
            r2_nd  <= r1_nd;
            r2_nu  <= r1_nu;
            r2_cut <= r1_cut;
        end
    end

    // ---------------- stage 3: fiducial cut ----------------
    logic [CW-1:0]        n3_r2;
    logic                 r3_fid;
    logic signed [TB-1:0] r3_t [8];
    logic [7:0]           r3_ok;
    logic [2:0]           r3_nd, r3_nu;
    t_cut                 r3_cut;

    assign n3_r2 = CW'(r2_dx2) + CW'(r2_dy2);

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_fid <= n3_r2 >= CW'(r_radius_sq);
            r3_t   <= r2_t;
            r3_ok  <= r2_ok;
            r3_nd  <= r2_nd;
            r3_nu  <= r2_nu;
            r3_cut <= r2_cut;
        end
    end

    // ---------------- stage 4: deviations, status ----------------
    logic signed [TB:0]   n4_dd, n4_adj, n4_diff;
    logic [TB-1:0]        n4_tc;
    logic [TB-1:0]        n4_dev [7];
    logic [2:0]           n4_status;
    logic [3:0]           n4_count;

    always_comb begin
        n4_dd  = (TB+1)'(w_dm) - (TB+1)'(w_um);
        // round toward zero before the halving shift
        n4_adj = n4_dd + (TB+1)'(n4_dd[TB]);
        n4_tc  = n4_adj[TB:1];
        for (int c = 0; c < 7; c++) begin
            n4_diff = (c < 4) ? (TB+1)'(r3_t[c]) - (TB+1)'(w_dm)
                              : (TB+1)'(r3_t[c]) - (TB+1)'(w_m3);
            if (n4_diff[TB]) n4_diff = -n4_diff;
            n4_dev[c] = r3_ok[c] ? n4_diff[TB-1:0] : '0;
        end
        priority if (r3_cut.trk)             n4_status = ST_TRACK;
        else if (r3_cut.peak)                n4_status = ST_PEAK;
        else if (r3_cut.reft)                n4_status = ST_REFT;
        else if (r3_fid)                     n4_status = ST_FID;
        else if (r3_cut.energy)              n4_status = ST_ENERGY;
        else if (r3_nd == '0 || r3_nu == '0) n4_status = ST_EMPTY;
        else                                 n4_status = ST_OK;
        n4_count = (n4_status == ST_OK || n4_status == ST_EMPTY)
                 ? 4'(r3_nd) + 4'(r3_nu) : 4'd0;
    end

    logic [TB-1:0] r4_tc;
    logic [TB-1:0] r4_dev [7];
    logic [2:0]    r4_status;
    logic [3:0]    r4_count;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_tc     <= n4_tc;
            r4_dev    <= n4_dev;
            r4_status <= n4_status;
            r4_count  <= n4_count;
        end
    end

    // ---------------- stage 5: max, output register ----------------
    logic [TB-1:0]         n5_max;
    logic [2:0]            r5_status;
    logic [FIELD_BITS-1:0] r5_time_diff;
    logic [FIELD_BITS-1:0] r5_worst_dev;
    logic [3:0]            r5_count;

    always_comb begin
        n5_max = '0;
        for (int c = 0; c < 7; c++) begin
            if (r4_dev[c] > n5_max) n5_max = r4_dev[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r5_status    <= r4_status;
            r5_time_diff <= (r4_status == ST_OK)
                          ? FIELD_BITS'(signed'(r4_tc)) : '0;
            r5_worst_dev <= (r4_status == ST_OK) ? FIELD_BITS'(n5_max) : '0;
            r5_count     <= r4_count;
        end
    end

    assign o_status          = r5_status;
    assign o_time_diff       = r5_time_diff;
    assign o_worst_deviation = r5_worst_dev;
    assign o_channel_count   = r5_count;

    // ---------------- assertions ----------------
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_time_diff == '0 && o_worst_deviation == '0)
        else $error("rejected event carries timing");

    a_cut_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK && o_status != ST_EMPTY |-> o_channel_count == 4'd0)
        else $error("cut event carries a channel count");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_channel_count >= 4'd2 && o_channel_count <= 4'd8)
        else $error("accepted event with impossible channel count");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v == '1 && i_stall)
        else $error("input stalled while a stage is free");

endmodule

### hdl/etq_mean.sv
// ----------------------------------------------------------------------------
// etq_mean
// Two-stage signed mean of up to four times, truncated toward zero.
// ----------------------------------------------------------------------------
module etq_mean
    import etq_pkg::*;
#(
    parameter int TB = 16
) (
    input  logic                 i_clk,
    input  t_mean_en             i_en,
    input  logic signed [TB+1:0] i_sum,
    input  logic [2:0]           i_cnt,
    output logic signed [TB-1:0] o_mean
);

    // divide by three as multiply by reciprocal, exact for |sum| < 2^(TB+1)
    localparam int SH    = TB + 2;
    localparam int RW    = SH - 1;
    localparam int RECIP = (2 ** SH) / 3 + 1;
    localparam int PW    = TB + 1 + RW;

    logic [TB+1:0]        n_mag;
    logic [PW-1:0]        n_prod;
    logic [TB-1:0]        n_q;
    logic [TB-1:0]        r_q;
    logic                 r_neg;
    logic signed [TB-1:0] r_mean;

    always_comb begin
        n_mag  = i_sum[TB+1] ? -i_sum : i_sum;
        n_prod = PW'(n_mag[TB:0]) * PW'(RECIP);
        unique case (i_cnt)
            3'd1:    n_q = n_mag[TB-1:0];
            3'd2:    n_q = n_mag[TB:1];
            3'd3:    n_q = n_prod[SH +: TB];
            3'd4:    n_q = n_mag[TB+1:2];
            default: n_q = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_q   <= n_q;
            r_neg <= i_sum[TB+1];
        end
        if (i_en.b) begin
            r_mean <= r_neg ? -signed'(r_q) : signed'(r_q);
        end
    end

    assign o_mean = r_mean;

endmodule
